// File: src/ptc_pkg.sv
// Package: shared types, constants and helpers for the compensation pipeline.
`timescale 1ns / 1ps
`default_nettype none
package ptc_pkg;

  localparam int unsigned DivW = 32;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [63:0] plo;
    logic [63:0] phi;
  } coeff_t;

  typedef enum logic [2:0] {
    REG_T1   = 3'd0,
    REG_T2   = 3'd1,
    REG_T3   = 3'd2,
    REG_P1   = 3'd3,
    REG_PLO  = 3'd4,
    REG_PHI  = 3'd5
  } reg_idx_t;

  // 32-bit arithmetic right shift
  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    logic signed [31:0] s;
    s = signed'(x);
    return 32'(s >>> n);
  endfunction

  // sign extend 16 to 32
  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage
`default_nettype wire

// File: src/ptc_div.sv
// Pipelined restoring unsigned divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module ptc_div #(
  parameter int unsigned W = ptc_pkg::DivW
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] num,
  input  wire logic [W-1:0] den,
  output logic [W-1:0]      quo
);
  logic [W-1:0] n_r [W+1];
  logic [W-1:0] r_r [W+1];
  logic [W-1:0] d_r [W+1];

  always_comb begin
    n_r[0] = num;
    r_r[0] = '0;
    d_r[0] = den;
  end

  // each stage shifts in one numerator bit and tries a subtract
  for (genvar i = 0; i < W; i++) begin : g_st
    logic [W:0] rs;
    logic [W:0] df;
    always_comb begin
      rs = {r_r[i], n_r[i][W-1]};
      df = rs - {1'b0, d_r[i]};
    end
    logic [W-1:0] nq_r, rr_r, dd_r;
    always_ff @(posedge clk) begin
      if (en) begin
        dd_r <= d_r[i];
        nq_r <= {n_r[i][W-2:0], ~df[W]};
        rr_r <= df[W] ? rs[W-1:0] : df[W-1:0];
      end
    end
    always_comb begin
      n_r[i+1] = nq_r;
      r_r[i+1] = rr_r;
      d_r[i+1] = dd_r;
    end
  end

  assign quo = n_r[W];
endmodule
`default_nettype wire

// File: src/pressure_temperature_compensation_top.sv
// Top level: pipelined barometric temperature and pressure compensation.
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/stall   | raw_temperature, raw_pressure
//  out_    | output    | out_valid/stall  | fine, centi, pressure, dz flag
//  cfg_    | input     | cfg_valid/ready  | cfg_index, cfg_data
//
// The pipe has 12 arithmetic stages, 32 divider stages and 8 more.
// One item enters per cycle; the whole pipe advances whenever out_stall is
// low or a bubble sits in the output register.
// Reset clears valid bits and coefficients; payload registers are not reset.
// Stall freezes every stage, so nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module pressure_temperature_compensation_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [19:0]        in_raw_temperature,
  input  wire logic [19:0]        in_raw_pressure,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_fine_temperature,
  output logic signed [31:0]      out_temperature_centi,
  output logic [31:0]             out_pressure_pa,
  output logic                    out_divide_by_zero,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_data
);
  localparam int unsigned DIV_W = ptc_pkg::DivW;
  localparam int unsigned NPre = 12;
  localparam int unsigned NPost = 8;
  localparam int unsigned NV = NPre + DIV_W + NPost;

  ptc_pkg::coeff_t cf_r;
  logic en;
  logic [NV-1:0] v_r;

  assign cfg_ready = 1'b1;
  assign en = ~(v_r[NV-1] & out_stall);
  assign in_stall = ~en;
  assign out_valid = v_r[NV-1];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cf_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ptc_pkg::REG_T1:  cf_r.t1 <= cfg_data[15:0];
        ptc_pkg::REG_T2:  cf_r.t2 <= cfg_data[15:0];
        ptc_pkg::REG_T3:  cf_r.t3 <= cfg_data[15:0];
        ptc_pkg::REG_P1:  cf_r.p1 <= cfg_data[15:0];
        ptc_pkg::REG_PLO: cf_r.plo <= cfg_data;
        ptc_pkg::REG_PHI: cf_r.phi <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid shift line
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[NV-2:0], in_valid};
  end

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  always_comb begin
    t1 = {16'd0, cf_r.t1};
    t2 = ptc_pkg::sx16(cf_r.t2);
    t3 = ptc_pkg::sx16(cf_r.t3);
    p1 = {16'd0, cf_r.p1};
    p2 = ptc_pkg::sx16(cf_r.plo[15:0]);
    p3 = ptc_pkg::sx16(cf_r.plo[31:16]);
    p4 = ptc_pkg::sx16(cf_r.plo[47:32]);
    p5 = ptc_pkg::sx16(cf_r.plo[63:48]);
    p6 = ptc_pkg::sx16(cf_r.phi[15:0]);
    p7 = ptc_pkg::sx16(cf_r.phi[31:16]);
    p8 = ptc_pkg::sx16(cf_r.phi[47:32]);
    p9 = ptc_pkg::sx16(cf_r.phi[63:48]);
  end

  // pressure raw travels along the front section, ready at s12 input
  logic [19:0] adp_r [NPre-1];
  always_ff @(posedge clk) begin
    if (en) begin
      adp_r[0] <= in_raw_pressure;
      for (int i = 1; i < NPre - 1; i++) adp_r[i] <= adp_r[i-1];
    end
  end

  // s1: operands
  logic [31:0] s1_x_r, s1_d_r;
  // s2: products
  logic [31:0] s2_a_r, s2_dd_r;
  // s3
  logic [31:0] s3_a_r, s3_m_r;
  // s4
  logic [31:0] s4_fine_r;
  // temp fine tracks, centi
  logic [31:0] s5_fine_r, s5_f5_r, s5_a_r;
  logic [31:0] s6_fine_r, s6_centi_r, s6_a_r, s6_d_r;
  logic [31:0] s7_fine_r, s7_centi_r, s7_a_r, s7_q2_r;
  logic [31:0] s8_fine_r, s8_centi_r, s8_b_r, s8_m5_r, s8_m3_r, s8_m2_r;
  logic [31:0] s9_fine_r, s9_centi_r, s9_b_r, s9_a_r;
  logic [31:0] s10_fine_r, s10_centi_r, s10_b_r, s10_m_r;
  logic [31:0] s11_fine_r, s11_centi_r, s11_b_r, s11_div_r;
  logic [31:0] s12_fine_r, s12_centi_r, s12_div_r, s12_num_r;
  logic s12_dz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x_r <= {15'd0, in_raw_temperature[19:3]} - {t1[30:0], 1'b0};
      s1_d_r <= {16'd0, in_raw_temperature[19:4]} - t1;
      s2_a_r <= 32'(s1_x_r * t2);
      s2_dd_r <= 32'(s1_d_r * s1_d_r);
      s3_a_r <= ptc_pkg::asr(s2_a_r, 11);
      s3_m_r <= 32'(ptc_pkg::asr(s2_dd_r, 12) * t3);
      s4_fine_r <= s3_a_r + ptc_pkg::asr(s3_m_r, 14);
      // s5
      s5_fine_r <= s4_fine_r;
      s5_f5_r <= 32'(s4_fine_r * 32'd5);
      s5_a_r <= ptc_pkg::asr(s4_fine_r, 1) - 32'd64000;
      // s6
      s6_fine_r <= s5_fine_r;
      s6_centi_r <= ptc_pkg::asr(s5_f5_r + 32'd128, 8);
      s6_a_r <= s5_a_r;
      s6_d_r <= ptc_pkg::asr(s5_a_r, 2);
      // s7
      s7_fine_r <= s6_fine_r; s7_centi_r <= s6_centi_r;
      s7_a_r <= s6_a_r;
      s7_q2_r <= 32'(s6_d_r * s6_d_r);
      // s8
      s8_fine_r <= s7_fine_r; s8_centi_r <= s7_centi_r;
      s8_b_r <= 32'(ptc_pkg::asr(s7_q2_r, 11) * p6);
      s8_m5_r <= 32'(s7_a_r * p5);
      s8_m3_r <= 32'(p3 * ptc_pkg::asr(s7_q2_r, 13));
      s8_m2_r <= 32'(p2 * s7_a_r);
      // s9
      s9_fine_r <= s8_fine_r; s9_centi_r <= s8_centi_r;
      s9_b_r <= ptc_pkg::asr(s8_b_r + {s8_m5_r[30:0], 1'b0}, 2) + {p4[15:0], 16'd0};
      s9_a_r <= ptc_pkg::asr(ptc_pkg::asr(s8_m3_r, 3) + ptc_pkg::asr(s8_m2_r, 1), 18);
      // s10
      s10_fine_r <= s9_fine_r; s10_centi_r <= s9_centi_r;
      s10_b_r <= s9_b_r;
      s10_m_r <= 32'((32'd32768 + s9_a_r) * p1);
      // s11
      s11_fine_r <= s10_fine_r; s11_centi_r <= s10_centi_r;
      s11_b_r <= s10_b_r;
      s11_div_r <= ptc_pkg::asr(s10_m_r, 15);
      // s12: numerator scaled
      s12_fine_r <= s11_fine_r; s12_centi_r <= s11_centi_r;
      s12_div_r <= s11_div_r;
      s12_dz_r <= (s11_div_r == 32'd0);
      s12_num_r <= 32'(((32'd1048576 - {12'd0, adp_r[NPre-2]})
                         - ptc_pkg::asr(s11_b_r, 12)) * 32'd3125);
    end
  end

  // divider input: numerator doubled when its top bit is clear
  logic pre_dbl;
  logic [DIV_W-1:0] dv_num, dv_quo;
  assign pre_dbl = ~s12_num_r[31];
  assign dv_num = DIV_W'(pre_dbl ? {s12_num_r[30:0], 1'b0} : s12_num_r);

  ptc_div #(.W(DIV_W)) u_div (
    .clk(clk), .en(en), .num(dv_num), .den(DIV_W'(s12_div_r)), .quo(dv_quo)
  );

  // side data delayed alongside the divider
  logic [31:0] dl_fine_r [DIV_W];
  logic [31:0] dl_centi_r [DIV_W];
  logic dl_dz_r [DIV_W];
  logic dl_pd_r [DIV_W];
  always_ff @(posedge clk) begin
    if (en) begin
      dl_fine_r[0] <= s12_fine_r; dl_centi_r[0] <= s12_centi_r;
      dl_dz_r[0] <= s12_dz_r; dl_pd_r[0] <= pre_dbl;
      for (int i = 1; i < DIV_W; i++) begin
        dl_fine_r[i] <= dl_fine_r[i-1]; dl_centi_r[i] <= dl_centi_r[i-1];
        dl_dz_r[i] <= dl_dz_r[i-1]; dl_pd_r[i] <= dl_pd_r[i-1];
      end
    end
  end

  // post section
  logic [31:0] q0;
  assign q0 = dl_pd_r[DIV_W-1] ? 32'(dv_quo) : {dv_quo[DIV_W-2:0], 1'b0};

  logic [31:0] f_r [NPost];
  logic [31:0] c_r [NPost];
  logic z_r [NPost];
  logic [31:0] u1_p_r, u1_sq_r, u1_m8_r;
  logic [31:0] u2_p_r, u2_a_r, u2_b_r;
  logic [31:0] u3_p_r;
  logic [31:0] pp_r [3:NPost-1];

  always_ff @(posedge clk) begin
    if (en) begin
      f_r[0] <= dl_fine_r[DIV_W-1]; c_r[0] <= dl_centi_r[DIV_W-1];
      z_r[0] <= dl_dz_r[DIV_W-1];
      for (int i = 1; i < NPost; i++) begin
        f_r[i] <= f_r[i-1]; c_r[i] <= c_r[i-1]; z_r[i] <= z_r[i-1];
      end
      // u1
      u1_p_r <= q0;
      u1_sq_r <= 32'({3'd0, q0[31:3]} * {3'd0, q0[31:3]});
      u1_m8_r <= 32'({2'd0, q0[31:2]} * p8);
      // u2
      u2_p_r <= u1_p_r;
      u2_a_r <= 32'(p9 * {13'd0, u1_sq_r[31:13]});
      u2_b_r <= ptc_pkg::asr(u1_m8_r, 13);
      // u3
      u3_p_r <= u2_p_r + ptc_pkg::asr(ptc_pkg::asr(u2_a_r, 12) + u2_b_r + p7, 4);
      pp_r[3] <= z_r[2] ? 32'd0 : u3_p_r;
      for (int i = 4; i < NPost; i++) pp_r[i] <= pp_r[i-1];
    end
  end

  assign out_fine_temperature = signed'(f_r[NPost-1]);
  assign out_temperature_centi = signed'(c_r[NPost-1]);
  assign out_pressure_pa = pp_r[NPost-1];
  assign out_divide_by_zero = z_r[NPost-1];
endmodule
`default_nettype wire

// File: src/ptc_checker.sv
// Port-level checker for the compensation top level, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module ptc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_pressure_pa,
  input wire logic        out_divide_by_zero,
  input wire logic        cfg_ready
);
  // a zero-divisor result carries zero pressure
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> out_pressure_pa == 32'd0)
    else $error("dz result with nonzero pressure");
  // input stalls only when a held result is blocked
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");
  // a stalled result stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pressure_pa))
    else $error("stalled result changed");
  // config always ready
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config not ready");
endmodule

bind pressure_temperature_compensation_top ptc_checker u_ptc_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_pressure_pa(out_pressure_pa),
  .out_divide_by_zero(out_divide_by_zero), .cfg_ready(cfg_ready)
);
`default_nettype wire
